// File: hw/rtl/tnrf_pkg.sv
// tnrf_pkg: telnet codes, parser phase type and the result word type
// for the telnet receive filter. No dependencies.
`default_nettype none

package tnrf_pkg;

    localparam logic [7:0] TN_IAC  = 8'd255;
    localparam logic [7:0] TN_DONT = 8'd254;
    localparam logic [7:0] TN_DO   = 8'd253;
    localparam logic [7:0] TN_WONT = 8'd252;
    localparam logic [7:0] TN_WILL = 8'd251;
    localparam logic [7:0] TN_SB   = 8'd250;
    localparam logic [7:0] TN_SE   = 8'd240;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_NUL  = 8'h00;

    typedef enum logic [4:0] {
        PH_DATA    = 5'b00001,
        PH_CMD     = 5'b00010,
        PH_OPTION  = 5'b00100,
        PH_SUB     = 5'b01000,
        PH_SUB_IAC = 5'b10000
    } t_phase;

    typedef struct packed {
        logic       emit;
        logic [7:0] data;
    } t_parse_out;

endpackage

`default_nettype wire

// File: hw/rtl/telnet_receive_filter.sv
// telnet_receive_filter: top level, input word register and result register
// around the parser. Depends on tnrf_pkg and tnrf_parser.
`default_nettype none

// Filters a received telnet byte stream down to user data. One word enters
// per cycle while o_ready is high; each word is parsed while it waits in the
// input register, and its result (if any) is loaded into the output register
// as the word leaves the input register. Words that are telnet commands,
// dropped NUL/LF after CR, or restarts produce no output word. A stalled
// output holds the input register, which in turn holds o_ready low;
// throughput is one word per cycle while i_ready is high.
module telnet_receive_filter
    import tnrf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_session_restart,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_user_byte
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_restart;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       s_step;
    t_parse_out s_result;

    // input word moves on when the result register is free or draining
    assign s_step  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || s_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte    <= i_rx_byte;
            r_in_restart <= i_session_restart;
        end
    end

    tnrf_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (s_step),
        .i_rx_byte (r_in_byte),
        .i_restart (r_in_restart),
        .o_result  (s_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_step) begin
            r_out_valid <= s_result.emit;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_step && s_result.emit) begin
            r_out_byte <= s_result.data;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_user_byte = r_out_byte;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("pipeline not empty after reset");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_ready |=> r_in_valid && $stable(r_in_byte))
        else $error("input word lost during output stall");

    a_step_frees_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_step && !s_result.emit |=> !o_valid)
        else $error("stale output word after silent step");

endmodule

`default_nettype wire

// File: hw/rtl/tnrf_parser.sv
// tnrf_parser: telnet command state machine and CR/NUL/LF filter.
// Steps once per word presented on i_step. Depends on tnrf_pkg.
`default_nettype none

module tnrf_parser
    import tnrf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_restart,
    output t_parse_out      o_result
);

    t_phase r_phase, n_phase;
    logic   r_after_cr, n_after_cr;

    always_comb begin
        n_phase       = r_phase;
        n_after_cr    = r_after_cr;
        o_result.emit = 1'b0;
        o_result.data = i_rx_byte;
        if (i_restart) begin
            n_phase    = PH_DATA;
            n_after_cr = 1'b0;
        end else begin
            case (r_phase)
                PH_CMD: begin
                    if (i_rx_byte == TN_IAC) begin
                        // escaped 255: leaves the CR mark alone
                        o_result.emit = 1'b1;
                        n_phase       = PH_DATA;
                    end else if (i_rx_byte == TN_SB) begin
                        n_phase = PH_SUB;
                    end else if (i_rx_byte == TN_WILL || i_rx_byte == TN_WONT ||
                                 i_rx_byte == TN_DO   || i_rx_byte == TN_DONT) begin
                        n_phase = PH_OPTION;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_OPTION: begin
                    n_phase = PH_DATA;
                end
                PH_SUB: begin
                    if (i_rx_byte == TN_IAC) begin
                        n_phase = PH_SUB_IAC;
                    end
                end
                PH_SUB_IAC: begin
                    n_phase = (i_rx_byte == TN_SE) ? PH_DATA : PH_SUB;
                end
                default: begin
                    n_phase = PH_DATA;
                    if (i_rx_byte == TN_IAC) begin
                        n_phase = PH_CMD;
                    end else if (r_after_cr &&
                                 (i_rx_byte == CH_NUL || i_rx_byte == CH_LF)) begin
                        n_after_cr = 1'b0;
                    end else begin
                        o_result.emit = 1'b1;
                        n_after_cr    = (i_rx_byte == CH_CR);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_DATA;
            r_after_cr <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_after_cr <= n_after_cr;
        end
    end

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_restart |=> r_phase == PH_DATA && !r_after_cr)
        else $error("restart did not return parser to data phase");

    a_option_swallowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_restart && r_phase == PH_OPTION |-> !o_result.emit)
        else $error("option byte passed through");

    a_crlf_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_restart && r_phase == PH_DATA && r_after_cr && o_result.emit
        |-> i_rx_byte != CH_NUL && i_rx_byte != CH_LF)
        else $error("NUL or LF after CR was delivered");

endmodule

`default_nettype wire
